### hw/rtl/rrtt_pkg.sv
// shared constants, result kinds and controller/datapath interface structs
// for the round-robin task table; no dependencies
package rrtt_pkg;

    localparam int MAX_TASKS   = 8;
    localparam int STACK_WORDS = 512;
    localparam int IDX_W       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    localparam logic [31:0] SLOT_BYTES    = 32'(STACK_WORDS * 4);
    localparam logic [31:0] FRAME_OFS     = 32'((STACK_WORDS - 17) * 4);
    localparam logic [31:0] OFS_EXC_RET   = 32'(8 * 4);
    localparam logic [31:0] OFS_ENTRY     = 32'(15 * 4);
    localparam logic [31:0] OFS_PSR       = 32'(16 * 4);
    localparam logic [31:0] LR_FRAME_WORD = 32'hFFFF_FFFD;
    localparam logic [31:0] THUMB_PSR     = 32'h0100_0000;

    localparam logic [1:0] OP_CREATE   = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_FINISH   = 2'd2;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd3;

    localparam logic [2:0] RS_OK          = 3'd0;
    localparam logic [2:0] RS_FULL        = 3'd1;
    localparam logic [2:0] RS_NONE_READY  = 3'd2;
    localparam logic [2:0] RS_UNSUPPORTED = 3'd3;
    localparam logic [2:0] RS_NO_CURRENT  = 3'd4;

    localparam logic [7:0] SC_NONE      = 8'd0;
    localparam logic [7:0] SC_GET_ID    = 8'd1;
    localparam logic [7:0] SC_GET_PRIO  = 8'd2;
    localparam logic [7:0] SC_GET_EXEC  = 8'd3;

    typedef logic [2:0] t_kind;
    localparam t_kind K_FULL       = 3'd0;
    localparam t_kind K_FRAME0     = 3'd1;
    localparam t_kind K_FRAME1     = 3'd2;
    localparam t_kind K_FRAME2     = 3'd3;
    localparam t_kind K_DISPATCH   = 3'd4;
    localparam t_kind K_NONE_READY = 3'd5;
    localparam t_kind K_FINISH     = 3'd6;
    localparam t_kind K_NO_CURRENT = 3'd7;

    typedef struct packed {
        logic  load;
        logic  step;
        logic  prep;
        logic  emit;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_op;
        logic [1:0] op;
        logic       hit;
        logic       scan_last;
        logic       finish_ok;
        logic       out_free;
    } t_sts;

endpackage

### hw/rtl/round_robin_task_table.sv
// top level of the round-robin task table: controller plus datapath
// depends on rrtt_pkg, rrtt_ctrl and rrtt_dp
//
// Hardware task table for up to eight tasks. Create takes the first free slot and
// gives three stack-frame write items (the last one marked); dispatch picks the next
// ready slot after the current one, round-robin; finish charges elapsed ticks,
// saves the stack pointer and answers the query syscall. One item is worked on at a
// time and the input is stalled until its last result has been loaded into the output
// register. The slot scan visits one slot per cycle; finish skips the scan, and any
// result waits out an output stall. The stack region base must be written through
// i_cfg_we / i_cfg_data only while idle; the block itself does not enforce this.
module round_robin_task_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_priority_req,
    input  logic [31:0] i_entry_address,
    input  logic [31:0] i_now_ticks,
    input  logic [31:0] i_saved_stack_pointer,
    input  logic [7:0]  i_syscall_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_task_id,
    output logic [31:0] o_resume_stack_pointer,
    output logic        o_write_enable,
    output logic [31:0] o_write_address,
    output logic [31:0] o_write_data,
    output logic [31:0] o_return_value,
    output logic        o_last
);

    rrtt_pkg::t_cmd cmd;
    rrtt_pkg::t_sts sts;

    rrtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rrtt_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_data             (i_cfg_data),
        .i_operation            (i_operation),
        .i_priority_req         (i_priority_req),
        .i_entry_address        (i_entry_address),
        .i_now_ticks            (i_now_ticks),
        .i_saved_stack_pointer  (i_saved_stack_pointer),
        .i_syscall_code         (i_syscall_code),
        .i_out_stall            (i_out_stall),
        .o_out_valid            (o_out_valid),
        .o_status               (o_status),
        .o_task_id              (o_task_id),
        .o_resume_stack_pointer (o_resume_stack_pointer),
        .o_write_enable         (o_write_enable),
        .o_write_address        (o_write_address),
        .o_write_data           (o_write_data),
        .o_return_value         (o_return_value),
        .o_last                 (o_last),
        .i_cmd                  (cmd),
        .o_sts                  (sts)
    );

endmodule

### hw/rtl/rrtt_ctrl.sv
// controller state machine of the task table: accept, slot scan, result emit
// depends on rrtt_pkg
module rrtt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  rrtt_pkg::t_sts  i_sts,
    output rrtt_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    rrtt_pkg::t_kind     r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= rrtt_pkg::K_FULL;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_op == rrtt_pkg::OP_CREATE ||
                        i_sts.in_op == rrtt_pkg::OP_DISPATCH) begin
                        n_state = S_SCAN;
                    end else if (i_sts.in_op == rrtt_pkg::OP_FINISH) begin
                        n_state = S_EMIT;
                        n_kind  = i_sts.finish_ok ? rrtt_pkg::K_FINISH
                                                  : rrtt_pkg::K_NO_CURRENT;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    n_state = S_EMIT;
                    if (i_sts.op == rrtt_pkg::OP_CREATE) begin
                        o_cmd.prep = 1'b1;
                        n_kind     = rrtt_pkg::K_FRAME0;
                    end else begin
                        n_kind = rrtt_pkg::K_DISPATCH;
                    end
                end else if (i_sts.scan_last) begin
                    n_state = S_EMIT;
                    n_kind  = (i_sts.op == rrtt_pkg::OP_CREATE) ? rrtt_pkg::K_FULL
                                                                : rrtt_pkg::K_NONE_READY;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_kind == rrtt_pkg::K_FRAME0) begin
                        n_kind = rrtt_pkg::K_FRAME1;
                    end else if (r_kind == rrtt_pkg::K_FRAME1) begin
                        n_kind = rrtt_pkg::K_FRAME2;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/rrtt_dp.sv
// datapath of the task table: slot state, input latch, scan pointer,
// frame address and result register; depends on rrtt_pkg
module rrtt_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_data,
    input  logic [1:0]      i_operation,
    input  logic [7:0]      i_priority_req,
    input  logic [31:0]     i_entry_address,
    input  logic [31:0]     i_now_ticks,
    input  logic [31:0]     i_saved_stack_pointer,
    input  logic [7:0]      i_syscall_code,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [2:0]      o_status,
    output logic [3:0]      o_task_id,
    output logic [31:0]     o_resume_stack_pointer,
    output logic            o_write_enable,
    output logic [31:0]     o_write_address,
    output logic [31:0]     o_write_data,
    output logic [31:0]     o_return_value,
    output logic            o_last,
    input  rrtt_pkg::t_cmd  i_cmd,
    output rrtt_pkg::t_sts  o_sts
);

    localparam int                      N   = rrtt_pkg::MAX_TASKS;
    localparam int                      IW  = rrtt_pkg::IDX_W;
    localparam logic [IW-1:0]           TOP = IW'(N - 1);

    logic [31:0]   r_base;
    logic          r_used   [N];
    logic [1:0]    r_slot_st[N];
    logic [7:0]    r_prio   [N];
    logic [31:0]   r_exec   [N];
    logic [31:0]   r_sp     [N];
    logic [IW-1:0] r_cur;
    logic          r_has_cur;
    logic [31:0]   r_run_start;

    logic [1:0]    r_op;
    logic [7:0]    r_prio_req;
    logic [31:0]   r_entry;
    logic [31:0]   r_now;
    logic [31:0]   r_saved_sp;
    logic [7:0]    r_code;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_cnt;
    logic [31:0]   r_frame_sp;

    logic          r_out_valid;
    logic [2:0]    r_o_status;
    logic [3:0]    r_o_id;
    logic [31:0]   r_o_resume;
    logic          r_o_we;
    logic [31:0]   r_o_waddr;
    logic [31:0]   r_o_wdata;
    logic [31:0]   r_o_rv;
    logic          r_o_last;

    logic [2:0]    n_o_status;
    logic [3:0]    n_o_id;
    logic [31:0]   n_o_resume;
    logic          n_o_we;
    logic [31:0]   n_o_waddr;
    logic [31:0]   n_o_wdata;
    logic [31:0]   n_o_rv;
    logic          n_o_last;

    logic [IW-1:0] cur_next;
    logic [IW-1:0] idx_next;
    logic [31:0]   n_exec;
    logic [3:0]    idx_id;
    logic [3:0]    cur_id;
    logic          out_free;

    assign cur_next = (r_cur == TOP) ? '0 : r_cur + IW'(1);
    assign idx_next = (r_idx == TOP) ? '0 : r_idx + IW'(1);
    assign idx_id   = 4'(r_idx) + 4'd1;
    assign cur_id   = 4'(r_cur) + 4'd1;
    assign n_exec   = r_exec[r_cur] + (r_now - r_run_start);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts           = '0;
        o_sts.in_op     = i_operation;
        o_sts.op        = r_op;
        o_sts.hit       = (r_op == rrtt_pkg::OP_CREATE)
                          ? !r_used[r_idx]
                          : (r_slot_st[r_idx] == rrtt_pkg::ST_READY);
        o_sts.scan_last = (r_cnt == TOP);
        o_sts.finish_ok = r_has_cur && (r_slot_st[r_cur] == rrtt_pkg::ST_RUNNING);
        o_sts.out_free  = out_free;
    end

    // configuration, input latch and scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_data;
        end
        if (i_cmd.load) begin
            r_op       <= i_operation;
            r_prio_req <= i_priority_req;
            r_entry    <= i_entry_address;
            r_now      <= i_now_ticks;
            r_saved_sp <= i_saved_stack_pointer;
            r_code     <= i_syscall_code;
            r_idx      <= (i_operation == rrtt_pkg::OP_DISPATCH && r_has_cur) ? cur_next : '0;
            r_cnt      <= '0;
        end else if (i_cmd.step) begin
            r_idx <= idx_next;
            r_cnt <= r_cnt + IW'(1);
        end
        if (i_cmd.prep) begin
            r_frame_sp <= r_base + 32'(r_idx) * rrtt_pkg::SLOT_BYTES + rrtt_pkg::FRAME_OFS;
        end
    end

    // slot table and current task
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_used[i]    <= 1'b0;
                r_slot_st[i] <= rrtt_pkg::ST_NONE;
                r_prio[i]    <= '0;
                r_exec[i]    <= '0;
            end
            r_cur       <= '0;
            r_has_cur   <= 1'b0;
            r_run_start <= '0;
        end else if (i_cmd.emit) begin
            if (i_cmd.kind == rrtt_pkg::K_FRAME0) begin
                r_used[r_idx]    <= 1'b1;
                r_slot_st[r_idx] <= rrtt_pkg::ST_READY;
                r_prio[r_idx]    <= r_prio_req;
            end else if (i_cmd.kind == rrtt_pkg::K_DISPATCH) begin
                r_slot_st[r_idx] <= rrtt_pkg::ST_RUNNING;
                r_cur            <= r_idx;
                r_has_cur        <= 1'b1;
                r_run_start      <= r_now;
            end else if (i_cmd.kind == rrtt_pkg::K_FINISH) begin
                r_exec[r_cur]    <= n_exec;
                r_slot_st[r_cur] <= rrtt_pkg::ST_READY;
            end
        end
    end

    // saved stack pointers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (i_cmd.kind == rrtt_pkg::K_FRAME0) begin
                r_sp[r_idx] <= r_frame_sp;
            end else if (i_cmd.kind == rrtt_pkg::K_FINISH) begin
                r_sp[r_cur] <= r_saved_sp;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_o_status = rrtt_pkg::RS_OK;
        n_o_id     = '0;
        n_o_resume = '0;
        n_o_we     = 1'b0;
        n_o_waddr  = '0;
        n_o_wdata  = '0;
        n_o_rv     = '0;
        n_o_last   = 1'b1;
        unique case (i_cmd.kind)
            rrtt_pkg::K_FULL: begin
                n_o_status = rrtt_pkg::RS_FULL;
            end
            rrtt_pkg::K_FRAME0: begin
                n_o_id    = idx_id;
                n_o_we    = 1'b1;
                n_o_waddr = r_frame_sp + rrtt_pkg::OFS_EXC_RET;
                n_o_wdata = rrtt_pkg::LR_FRAME_WORD;
                n_o_last  = 1'b0;
            end
            rrtt_pkg::K_FRAME1: begin
                n_o_id    = idx_id;
                n_o_we    = 1'b1;
                n_o_waddr = r_frame_sp + rrtt_pkg::OFS_ENTRY;
                n_o_wdata = r_entry;
                n_o_last  = 1'b0;
            end
            rrtt_pkg::K_FRAME2: begin
                n_o_id    = idx_id;
                n_o_we    = 1'b1;
                n_o_waddr = r_frame_sp + rrtt_pkg::OFS_PSR;
                n_o_wdata = rrtt_pkg::THUMB_PSR;
            end
            rrtt_pkg::K_DISPATCH: begin
                n_o_id     = idx_id;
                n_o_resume = r_sp[r_idx];
            end
            rrtt_pkg::K_NONE_READY: begin
                n_o_status = rrtt_pkg::RS_NONE_READY;
            end
            rrtt_pkg::K_FINISH: begin
                n_o_id = cur_id;
                if (r_code == rrtt_pkg::SC_GET_ID) begin
                    n_o_rv = 32'(cur_id);
                end else if (r_code == rrtt_pkg::SC_GET_PRIO) begin
                    n_o_rv = 32'(r_prio[r_cur]);
                end else if (r_code == rrtt_pkg::SC_GET_EXEC) begin
                    n_o_rv = n_exec;
                end else if (r_code != rrtt_pkg::SC_NONE) begin
                    n_o_status = rrtt_pkg::RS_UNSUPPORTED;
                end
            end
            rrtt_pkg::K_NO_CURRENT: begin
                n_o_status = rrtt_pkg::RS_NO_CURRENT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_status <= n_o_status;
            r_o_id     <= n_o_id;
            r_o_resume <= n_o_resume;
            r_o_we     <= n_o_we;
            r_o_waddr  <= n_o_waddr;
            r_o_wdata  <= n_o_wdata;
            r_o_rv     <= n_o_rv;
            r_o_last   <= n_o_last;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_status               = r_o_status;
    assign o_task_id              = r_o_id;
    assign o_resume_stack_pointer = r_o_resume;
    assign o_write_enable         = r_o_we;
    assign o_write_address        = r_o_waddr;
    assign o_write_data           = r_o_wdata;
    assign o_return_value         = r_o_rv;
    assign o_last                 = r_o_last;

endmodule

### tb/tb.sv
// testbench for round_robin_task_table: drives create/dispatch/finish items
// and checks every result against a scoreboard with its own copy of the slot table
// depends on rrtt_pkg and round_robin_task_table
`timescale 1ns / 100ps

module tb;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [7:0] SC_BAD_LOW  = 8'd4;
    localparam logic [7:0] SC_BAD_HIGH = 8'hFF;
    localparam int         SETTLE      = 24;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  priority_req;
        logic [31:0] entry_address;
        logic [31:0] now_ticks;
        logic [31:0] saved_stack_pointer;
        logic [7:0]  syscall_code;
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  task_id;
        logic [31:0] resume_stack_pointer;
        logic        write_enable;
        logic [31:0] write_address;
        logic [31:0] write_data;
        logic [31:0] return_value;
        logic        last;
    } t_reply;

    class t_scoreboard;
        logic [31:0] base;
        bit          used [rrtt_pkg::MAX_TASKS];
        logic [1:0]  slot_state [rrtt_pkg::MAX_TASKS];
        logic [7:0]  prio [rrtt_pkg::MAX_TASKS];
        logic [31:0] exec_time [rrtt_pkg::MAX_TASKS];
        logic [31:0] stack_ptr [rrtt_pkg::MAX_TASKS];
        int unsigned cur;
        bit          has_cur;
        logic [31:0] run_start;
        t_reply      reply_q [$];
        int          errors;
        int          mismatches;
        int          requests;
        int          replies;
        int          frame_writes;
        int          status_hits [8];

        function new();
            base = '0;
            cur = 0;
            has_cur = 1'b0;
            run_start = '0;
            errors = 0;
            mismatches = 0;
            requests = 0;
            replies = 0;
            frame_writes = 0;
            for (int i = 0; i < rrtt_pkg::MAX_TASKS; i++) begin
                used[i] = 1'b0;
                slot_state[i] = rrtt_pkg::ST_NONE;
                prio[i] = '0;
                exec_time[i] = '0;
                stack_ptr[i] = '0;
            end
            for (int i = 0; i < 8; i++) status_hits[i] = 0;
        endfunction

        function void set_base(logic [31:0] v);
            base = v;
        endfunction

        function int pending();
            return reply_q.size();
        endfunction

        function string show(t_reply r);
            return $sformatf("status=%0d id=%0d resume=%h we=%b addr=%h data=%h rv=%h last=%b",
                             r.status, r.task_id, r.resume_stack_pointer, r.write_enable,
                             r.write_address, r.write_data, r.return_value, r.last);
        endfunction

        // advance the slot table by one request and queue the replies it causes
        function void note_request(t_request q);
            int unsigned s;
            int unsigned start;
            bit          found;
            logic [31:0] sp;
            t_reply      r;
            r = '0;
            r.last = 1'b1;
            found = 1'b0;
            s = 0;
            requests++;
            unique case (q.operation)
                rrtt_pkg::OP_CREATE: begin
                    for (int i = 0; i < rrtt_pkg::MAX_TASKS; i++)
                        if (!found && !used[i]) begin
                            s = i;
                            found = 1'b1;
                        end
                    if (!found) begin
                        r.status = rrtt_pkg::RS_FULL;
                        reply_q.push_back(r);
                    end else begin
                        sp = base + 32'(s) * rrtt_pkg::SLOT_BYTES + rrtt_pkg::FRAME_OFS;
                        stack_ptr[s] = sp;
                        used[s] = 1'b1;
                        prio[s] = q.priority_req;
                        slot_state[s] = rrtt_pkg::ST_READY;
                        r.task_id = 4'(s + 1);
                        r.write_enable = 1'b1;
                        r.last = 1'b0;
                        r.write_address = sp + rrtt_pkg::OFS_EXC_RET;
                        r.write_data = rrtt_pkg::LR_FRAME_WORD;
                        reply_q.push_back(r);
                        r.write_address = sp + rrtt_pkg::OFS_ENTRY;
                        r.write_data = q.entry_address;
                        reply_q.push_back(r);
                        r.last = 1'b1;
                        r.write_address = sp + rrtt_pkg::OFS_PSR;
                        r.write_data = rrtt_pkg::THUMB_PSR;
                        reply_q.push_back(r);
                    end
                end
                rrtt_pkg::OP_DISPATCH: begin
                    start = has_cur ? cur + 1 : 0;
                    for (int i = 0; i < rrtt_pkg::MAX_TASKS; i++) begin
                        s = (start + i) % rrtt_pkg::MAX_TASKS;
                        if (!found && slot_state[s] == rrtt_pkg::ST_READY) begin
                            found = 1'b1;
                            slot_state[s] = rrtt_pkg::ST_RUNNING;
                            cur = s;
                            has_cur = 1'b1;
                            run_start = q.now_ticks;
                            r.task_id = 4'(s + 1);
                            r.resume_stack_pointer = stack_ptr[s];
                        end
                    end
                    if (!found) r.status = rrtt_pkg::RS_NONE_READY;
                    reply_q.push_back(r);
                end
                rrtt_pkg::OP_FINISH: begin
                    if (!has_cur || slot_state[cur] != rrtt_pkg::ST_RUNNING) begin
                        r.status = rrtt_pkg::RS_NO_CURRENT;
                    end else begin
                        exec_time[cur] = exec_time[cur] + (q.now_ticks - run_start);
                        stack_ptr[cur] = q.saved_stack_pointer;
                        unique case (q.syscall_code)
                            rrtt_pkg::SC_NONE: ;
                            rrtt_pkg::SC_GET_ID: r.return_value = 32'(cur + 1);
                            rrtt_pkg::SC_GET_PRIO: r.return_value = {24'd0, prio[cur]};
                            rrtt_pkg::SC_GET_EXEC: r.return_value = exec_time[cur];
                            default: r.status = rrtt_pkg::RS_UNSUPPORTED;
                        endcase
                        slot_state[cur] = rrtt_pkg::ST_READY;
                        r.task_id = 4'(cur + 1);
                    end
                    reply_q.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_reply got);
            t_reply want;
            replies++;
            if (reply_q.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing expected: %s", show(got));
                return;
            end
            want = reply_q.pop_front();
            status_hits[want.status]++;
            if (want.write_enable) frame_writes++;
            if (got.status !== want.status || got.task_id !== want.task_id ||
                got.resume_stack_pointer !== want.resume_stack_pointer ||
                got.write_enable !== want.write_enable ||
                got.write_address !== want.write_address ||
                got.write_data !== want.write_data ||
                got.return_value !== want.return_value || got.last !== want.last) begin
                errors++;
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch on result %0d", replies);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_operation = '0;
    logic [7:0]  i_priority_req = '0;
    logic [31:0] i_entry_address = '0;
    logic [31:0] i_now_ticks = '0;
    logic [31:0] i_saved_stack_pointer = '0;
    logic [7:0]  i_syscall_code = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [3:0]  o_task_id;
    logic [31:0] o_resume_stack_pointer;
    logic        o_write_enable;
    logic [31:0] o_write_address;
    logic [31:0] o_write_data;
    logic [31:0] o_return_value;
    logic        o_last;

    t_scoreboard    sb;
    bit             gaps_on = 1'b1;
    bit             stall_on = 1'b1;
    int             hold_left = 0;
    int             base_writes = 0;
    logic [31:0]    tick = '0;

    round_robin_task_table DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_operation            (i_operation),
        .i_priority_req         (i_priority_req),
        .i_entry_address        (i_entry_address),
        .i_now_ticks            (i_now_ticks),
        .i_saved_stack_pointer  (i_saved_stack_pointer),
        .i_syscall_code         (i_syscall_code),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_status               (o_status),
        .o_task_id              (o_task_id),
        .o_resume_stack_pointer (o_resume_stack_pointer),
        .o_write_enable         (o_write_enable),
        .o_write_address        (o_write_address),
        .o_write_data           (o_write_data),
        .o_return_value         (o_return_value),
        .o_last                 (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400_000;
        $display("tb: errors");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left = hold_left - 1;
            end else begin
                i_out_stall = stall_on && ($urandom_range(99) < 7);
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_reply got;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got.status = o_status;
            got.task_id = o_task_id;
            got.resume_stack_pointer = o_resume_stack_pointer;
            got.write_enable = o_write_enable;
            got.write_address = o_write_address;
            got.write_data = o_write_data;
            got.return_value = o_return_value;
            got.last = o_last;
            sb.check_result(got);
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic t_request mk_req(logic [1:0] op, logic [7:0] pr, logic [31:0] ea,
                                        logic [31:0] now, logic [31:0] sp, logic [7:0] sc);
        t_request q;
        q.operation = op;
        q.priority_req = pr;
        q.entry_address = ea;
        q.now_ticks = now;
        q.saved_stack_pointer = sp;
        q.syscall_code = sc;
        return q;
    endfunction

    task automatic send_item(input t_request q);
        while (gaps_on && $urandom_range(99) < 7) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_operation = q.operation;
        i_priority_req = q.priority_req;
        i_entry_address = q.entry_address;
        i_now_ticks = q.now_ticks;
        i_saved_stack_pointer = q.saved_stack_pointer;
        i_syscall_code = q.syscall_code;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_request(q);
    endtask

    task automatic send_op(logic [1:0] op, logic [7:0] pr, logic [31:0] ea,
                           logic [31:0] now, logic [7:0] sc);
        send_item(mk_req(op, pr, ea, now, $urandom, sc));
    endtask

    // lower valid and wait until every queued result has come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_base(logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        i_cfg_data = $urandom;
        sb.set_base(v);
        base_writes++;
    endtask

    function automatic logic [7:0] pick_syscall();
        if ($urandom_range(99) < 15)
            return 8'($urandom_range(32'(SC_BAD_LOW), 32'(SC_BAD_HIGH)));
        return 8'($urandom_range(32'(rrtt_pkg::SC_NONE), 32'(rrtt_pkg::SC_GET_EXEC)));
    endfunction

    // mostly dispatch/finish pairs with random content, plus noise items
    task automatic run_random(int count);
        int n;
        int r;
        n = 0;
        while (n < count) begin
            r = $urandom_range(99);
            if (r < 6) begin
                send_op(rrtt_pkg::OP_CREATE, rnd8(), $urandom, $urandom, rnd8());
                n++;
            end else if (r < 11) begin
                send_op(OP_UNUSED, rnd8(), $urandom, $urandom, rnd8());
            end else if (r < 16) begin
                send_op(rrtt_pkg::OP_FINISH, rnd8(), $urandom, $urandom, rnd8());
                n++;
            end else if (r < 18) begin
                send_op(rrtt_pkg::OP_DISPATCH, rnd8(), $urandom, $urandom, rnd8());
                n++;
            end else begin
                send_op(rrtt_pkg::OP_DISPATCH, rnd8(), $urandom, tick, rnd8());
                if ($urandom_range(99) < 5) tick = $urandom;
                else tick = tick + 32'($urandom_range(1, 2000));
                send_op(rrtt_pkg::OP_FINISH, rnd8(), $urandom, tick, pick_syscall());
                n += 2;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_base(32'h0000_0000);

        // empty table: finish and dispatch with nothing to act on, unused op, then two creates
        send_op(rrtt_pkg::OP_FINISH, rnd8(), $urandom, $urandom, rrtt_pkg::SC_GET_ID);
        send_op(rrtt_pkg::OP_DISPATCH, rnd8(), $urandom, $urandom, rnd8());
        send_op(OP_UNUSED, rnd8(), $urandom, $urandom, rnd8());
        send_op(rrtt_pkg::OP_CREATE, 8'h00, 32'h0000_0000, $urandom, rnd8());
        send_op(rrtt_pkg::OP_CREATE, 8'hFF, 32'hFFFF_FFFF, $urandom, rnd8());
        // first dispatch from slot 0, then dispatch over a running task
        send_op(rrtt_pkg::OP_DISPATCH, rnd8(), $urandom, 32'd0, rnd8());
        send_op(rrtt_pkg::OP_DISPATCH, rnd8(), $urandom, 32'd5, rnd8());
        send_op(rrtt_pkg::OP_DISPATCH, rnd8(), $urandom, 32'd7, rnd8());
        send_item(mk_req(rrtt_pkg::OP_FINISH, rnd8(), $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         rrtt_pkg::SC_NONE));
        send_op(rrtt_pkg::OP_FINISH, rnd8(), $urandom, $urandom, rrtt_pkg::SC_GET_ID);
        send_op(rrtt_pkg::OP_DISPATCH, rnd8(), $urandom, 32'd10, rnd8());
        send_item(mk_req(rrtt_pkg::OP_FINISH, rnd8(), $urandom, 32'd20, 32'h0000_0000,
                         rrtt_pkg::SC_GET_ID));
        // execution time across a tick counter wrap
        send_op(rrtt_pkg::OP_DISPATCH, rnd8(), $urandom, 32'hFFFF_FFF0, rnd8());
        send_op(rrtt_pkg::OP_FINISH, rnd8(), $urandom, 32'd5, rrtt_pkg::SC_GET_EXEC);
        send_op(rrtt_pkg::OP_DISPATCH, rnd8(), $urandom, 32'd6, rnd8());
        send_op(rrtt_pkg::OP_FINISH, rnd8(), $urandom, 32'd9, rrtt_pkg::SC_GET_PRIO);
        send_op(rrtt_pkg::OP_DISPATCH, rnd8(), $urandom, 32'd9, rnd8());
        send_op(rrtt_pkg::OP_FINISH, rnd8(), $urandom, 32'd12, SC_BAD_HIGH);
        send_op(rrtt_pkg::OP_DISPATCH, rnd8(), $urandom, 32'd12, rnd8());
        send_op(rrtt_pkg::OP_FINISH, rnd8(), $urandom, 32'd14, SC_BAD_LOW);
        drain();

        // frame addresses wrapping past the top of memory
        write_base(32'hFFFF_FFFF);
        send_op(rrtt_pkg::OP_CREATE, rnd8(), $urandom, $urandom, rnd8());
        send_op(rrtt_pkg::OP_CREATE, rnd8(), $urandom, $urandom, rnd8());
        drain();

        // fill the table, then one create too many
        write_base($urandom);
        repeat (5) send_op(rrtt_pkg::OP_CREATE, rnd8(), $urandom, $urandom, rnd8());
        drain();

        tick = 32'd100;
        write_base($urandom);
        run_random(75);
        drain();

        gaps_on = 1'b0;
        stall_on = 1'b0;
        write_base($urandom);
        run_random(75);
        drain();
        gaps_on = 1'b1;
        stall_on = 1'b1;

        // receiver holds off while the sender keeps offering items
        write_base($urandom);
        hold_left = 150;
        run_random(75);
        drain();

        write_base($urandom);
        run_random(75);
        drain();

        sb.errors += sb.pending();
        $display("covered %0d items, %0d results, %0d frame writes, %0d base settings",
                 sb.requests, sb.replies, sb.frame_writes, base_writes);
        $display("statuses: ok %0d, full %0d, none ready %0d, unsupported %0d, no current %0d",
                 sb.status_hits[rrtt_pkg::RS_OK], sb.status_hits[rrtt_pkg::RS_FULL],
                 sb.status_hits[rrtt_pkg::RS_NONE_READY],
                 sb.status_hits[rrtt_pkg::RS_UNSUPPORTED],
                 sb.status_hits[rrtt_pkg::RS_NO_CURRENT]);
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/rrtt_pkg.sv
hw/rtl/rrtt_ctrl.sv
hw/rtl/rrtt_dp.sv
hw/rtl/round_robin_task_table.sv
tb/tb.sv
